>>> design/rrps_pkg.sv
// ----------------------------------------------------------------------------
// rrps_pkg: shared types and codes of the round-robin process scheduler
// Request and response payloads, operation and result codes, slot states,
// and the command/status bundle between controller and datapath.
// ----------------------------------------------------------------------------
package rrps_pkg;

	localparam int MAX_SLOTS_DEF = 16;

	// request operations
	localparam logic [2:0] OP_CREATE_KERN = 3'd0;
	localparam logic [2:0] OP_CREATE_USER = 3'd1;
	localparam logic [2:0] OP_TICK        = 3'd2;
	localparam logic [2:0] OP_EXIT        = 3'd3;
	localparam logic [2:0] OP_QUERY       = 3'd4;

	// response status
	localparam logic [1:0] RES_OK      = 2'd0;
	localparam logic [1:0] RES_FULL    = 2'd1;
	localparam logic [1:0] RES_NO_SLOT = 2'd2;
	localparam logic [1:0] RES_HALTED  = 2'd3;

	// slot states
	localparam logic [1:0] SLOT_DEAD    = 2'd0;
	localparam logic [1:0] SLOT_READY   = 2'd1;
	localparam logic [1:0] SLOT_RUNNING = 2'd2;

	// initial frame sizes below the stack top
	localparam logic [31:0] KERN_FRAME = 32'd68;
	localparam logic [31:0] USER_FRAME = 32'd76;

	typedef struct packed {
		logic [2:0]  op;
		logic [31:0] saved_esp;
		logic [31:0] new_stack_top;
		logic [31:0] new_root;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] new_pid;
		logic [31:0] running_pid;
		logic [31:0] resume_esp;
		logic [31:0] resume_root;
		logic [31:0] kstack_top_out;
		logic        load_kstack;
		logic        switched;
	} rsp_t;

	typedef logic [3:0] cmd_code_t;

	localparam cmd_code_t CMD_NONE       = 4'd0;
	localparam cmd_code_t CMD_LOAD       = 4'd1;
	localparam cmd_code_t CMD_HALT_RES   = 4'd2;
	localparam cmd_code_t CMD_QUERY_RES  = 4'd3;
	localparam cmd_code_t CMD_FULL_RES   = 4'd4;
	localparam cmd_code_t CMD_SCAN_START = 4'd5;
	localparam cmd_code_t CMD_SCAN       = 4'd6;
	localparam cmd_code_t CMD_NOFREE_RES = 4'd7;
	localparam cmd_code_t CMD_CREATE     = 4'd8;
	localparam cmd_code_t CMD_LINK       = 4'd9;
	localparam cmd_code_t CMD_LEAVE      = 4'd10;
	localparam cmd_code_t CMD_FOLLOW     = 4'd11;
	localparam cmd_code_t CMD_SELECT     = 4'd12;
	localparam cmd_code_t CMD_STOP_RES   = 4'd13;
	localparam cmd_code_t CMD_REPORT     = 4'd14;
	localparam cmd_code_t CMD_PUSH       = 4'd15;

	typedef struct packed {
		cmd_code_t code;
	} dp_cmd_t;

	typedef struct packed {
		logic halted;
		logic is_create;
		logic is_tick;
		logic is_exit;
		logic full;
		logic slot_free;
		logic scan_last;
		logic walk_hit;
		logic walk_end;
	} dp_sts_t;

endpackage

>>> design/rrps_chan_if.sv
// ----------------------------------------------------------------------------
// rrps_chan_if: valid/ready channel
// Carries one payload of type T from a source to a sink.
// ----------------------------------------------------------------------------
interface rrps_chan_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> design/round_robin_process_scheduler.sv
// ----------------------------------------------------------------------------
// round_robin_process_scheduler: ring-linked process slot scheduler
// Query, halted and full-table create requests are staged straight from
// decode; any other create first runs the one-slot-per-cycle free scan, and
// a tick or exit first runs the one-hop-per-cycle ring walk through the slot
// table read port. One request at a time; the next is accepted the cycle
// after the response is staged in the output register.
// Reset (async, active low) leaves slot 0 running with pid 1; no clear pass.
// ----------------------------------------------------------------------------
module round_robin_process_scheduler #(
	parameter int MAX_SLOTS = rrps_pkg::MAX_SLOTS_DEF
) (
	input logic         clk,
	input logic         arst_n,
	input logic         cfg_we,
	input logic [31:0]  cfg_wdata,
	rrps_chan_if.sink   req,
	rrps_chan_if.source rsp
);

	rrps_pkg::dp_cmd_t cmd;
	rrps_pkg::dp_sts_t sts;
	rrps_pkg::rsp_t    rsp_data;

	rrps_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	rrps_dp #(
		.MAX_SLOTS (MAX_SLOTS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req_data  (req.data),
		.rsp_data  (rsp_data),
		.cmd       (cmd),
		.sts       (sts)
	);

	assign rsp.data = rsp_data;

	// an accepted request closes the input until its response is staged
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("request accepted while another is in flight");

	// staging never overwrites a response still waiting at the output
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.code == rrps_pkg::CMD_PUSH |-> (!rsp.valid || rsp.ready))
		else $error("response register overwritten before it was taken");

	// a selected slot is always reported in the next cycle
	a_select_report: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.code == rrps_pkg::CMD_SELECT |=> cmd.code == rrps_pkg::CMD_REPORT)
		else $error("slot selection not followed by report");

	// a response appears only from a staged result
	a_rsp_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp.valid) |-> $past(cmd.code == rrps_pkg::CMD_PUSH))
		else $error("response valid without a staged result");

endmodule

>>> design/rrps_dp.sv
// ----------------------------------------------------------------------------
// rrps_dp: scheduler datapath
// Slot table memories, current slot, pid counter, ring walk and scan index,
// result staging and output register.
// ----------------------------------------------------------------------------
module rrps_dp #(
	parameter int MAX_SLOTS = rrps_pkg::MAX_SLOTS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [31:0]      cfg_wdata,
	input  rrps_pkg::req_t   req_data,
	output rrps_pkg::rsp_t   rsp_data,
	input  rrps_pkg::dp_cmd_t cmd,
	output rrps_pkg::dp_sts_t sts
);

	localparam int IW = $clog2(MAX_SLOTS);
	localparam int CW = $clog2(MAX_SLOTS + 1);
	localparam logic [IW-1:0] LAST_IDX = IW'(MAX_SLOTS - 1);
	localparam logic [CW-1:0] CNT_MAX  = CW'(MAX_SLOTS);
	localparam logic [CW-1:0] CNT_LAST = CW'(MAX_SLOTS - 1);

	// slot record memories: the record fields share one write and one read port, esp and root have their own
	logic [31:0]   pid_mem  [MAX_SLOTS];
	logic [1:0]    st_mem   [MAX_SLOTS];
	logic [IW-1:0] link_mem [MAX_SLOTS];
	logic [31:0]   ks_mem   [MAX_SLOTS];
	logic          user_mem [MAX_SLOTS];
	logic [31:0]   esp_mem  [MAX_SLOTS];
	logic [31:0]   root_mem [MAX_SLOTS];

	logic [MAX_SLOTS-1:0] vld_q;

	// control state
	logic [31:0]   kroot_q;
	logic [IW-1:0] cur_q;
	logic [31:0]   pidc_q;
	logic [CW-1:0] live_q;
	logic          halt_q;
	logic [IW-1:0] idx_q;
	logic [CW-1:0] cnt_q;

	// payload registers
	rrps_pkg::req_t req_q;
	logic [31:0]    cur_pid_q;
	logic [1:0]     cur_st_q;
	logic [IW-1:0]  cur_link_q;
	logic [31:0]    cur_ks_q;
	logic           cur_user_q;
	logic [31:0]    sel_pid_q;
	logic [31:0]    sel_ks_q;
	logic           sel_user_q;
	logic           switched_q;
	rrps_pkg::rsp_t res_q;
	rrps_pkg::rsp_t out_q;

	logic [31:0]   rd_pid_q;
	logic [1:0]    rd_st_q;
	logic [IW-1:0] rd_link_q;
	logic [31:0]   rd_ks_q;
	logic          rd_user_q;
	logic          rd_vld_q;
	logic [IW-1:0] rd_addr_q;
	logic [31:0]   esp_rd_q;
	logic [31:0]   root_rd_q;

	// read data with never-written entries mapped to their reset record
	logic [31:0]   r_pid;
	logic [1:0]    r_st;
	logic [IW-1:0] r_link;
	logic [31:0]   r_ks;
	logic          r_user;

	// walk view: the current slot is taken from its own register
	logic          at_cur;
	logic [31:0]   v_pid;
	logic [1:0]    v_st;
	logic [IW-1:0] v_link;
	logic [31:0]   v_ks;
	logic          v_user;

	logic          is_create;
	logic          is_user_op;
	logic          is_tick;
	logic          is_exit;
	logic          walk_hit;
	logic [IW-1:0] nx;
	logic [31:0]   sel_pid;
	logic [31:0]   sel_ks;
	logic          sel_user;
	logic [31:0]   top;

	logic          rec_we;
	logic [IW-1:0] rec_wa;
	logic [31:0]   w_pid;
	logic [1:0]    w_st;
	logic [IW-1:0] w_link;
	logic [31:0]   w_ks;
	logic          w_user;
	logic          rec_re;
	logic [IW-1:0] rec_ra;
	logic          esp_we;
	logic [IW-1:0] esp_wa;
	logic [31:0]   esp_wd;
	logic          root_we;
	logic [31:0]   root_wd;
	logic          side_re;

	rrps_pkg::rsp_t res_d;
	logic           res_we;

	always_comb begin
		if (rd_vld_q) begin
			r_pid  = rd_pid_q;
			r_st   = rd_st_q;
			r_link = rd_link_q;
			r_ks   = rd_ks_q;
			r_user = rd_user_q;
		end else begin
			r_pid  = (rd_addr_q == '0) ? 32'd1 : 32'd0;
			r_st   = (rd_addr_q == '0) ? rrps_pkg::SLOT_RUNNING : rrps_pkg::SLOT_DEAD;
			r_link = '0;
			r_ks   = '0;
			r_user = 1'b0;
		end
	end

	assign at_cur = (idx_q == cur_q);
	assign v_pid  = at_cur ? cur_pid_q  : r_pid;
	assign v_st   = at_cur ? cur_st_q   : r_st;
	assign v_link = at_cur ? cur_link_q : r_link;
	assign v_ks   = at_cur ? cur_ks_q   : r_ks;
	assign v_user = at_cur ? cur_user_q : r_user;

	assign is_user_op = (req_q.op == rrps_pkg::OP_CREATE_USER);
	assign is_create  = (req_q.op == rrps_pkg::OP_CREATE_KERN) || is_user_op;
	assign is_tick    = (req_q.op == rrps_pkg::OP_TICK);
	assign is_exit    = (req_q.op == rrps_pkg::OP_EXIT);
	assign top        = req_q.new_stack_top;

	assign walk_hit = (v_st == rrps_pkg::SLOT_READY);
	assign nx       = walk_hit ? idx_q : cur_q;
	assign sel_pid  = walk_hit ? v_pid : cur_pid_q;
	assign sel_ks   = walk_hit ? v_ks : cur_ks_q;
	assign sel_user = walk_hit ? v_user : cur_user_q;

	assign sts.halted    = halt_q;
	assign sts.is_create = is_create;
	assign sts.is_tick   = is_tick;
	assign sts.is_exit   = is_exit;
	assign sts.full      = (live_q >= CNT_MAX);
	assign sts.slot_free = (r_st == rrps_pkg::SLOT_DEAD) && (r_pid == 32'd0);
	assign sts.scan_last = (idx_q == LAST_IDX);
	assign sts.walk_hit  = walk_hit;
	// tick checks once more after the last step, exit gives up at its own slot
	assign sts.walk_end  = is_tick ? (cnt_q == CNT_MAX) : (at_cur || (cnt_q == CNT_LAST));

	assign rsp_data = out_q;

	// memory port control
	always_comb begin
		rec_we  = 1'b0;
		rec_wa  = cur_q;
		w_pid   = cur_pid_q;
		w_st    = cur_st_q;
		w_link  = cur_link_q;
		w_ks    = cur_ks_q;
		w_user  = cur_user_q;
		rec_re  = 1'b0;
		rec_ra  = cur_q;
		esp_we  = 1'b0;
		esp_wa  = cur_q;
		esp_wd  = req_q.saved_esp;
		root_we = 1'b0;
		root_wd = kroot_q;
		side_re = 1'b0;
		case (cmd.code)
			rrps_pkg::CMD_LOAD: begin
				rec_re = 1'b1;
				rec_ra = cur_q;
			end
			rrps_pkg::CMD_SCAN_START: begin
				rec_re = 1'b1;
				rec_ra = '0;
			end
			rrps_pkg::CMD_SCAN: begin
				rec_re = 1'b1;
				rec_ra = idx_q + 1'b1;
			end
			rrps_pkg::CMD_CREATE: begin
				rec_we  = 1'b1;
				rec_wa  = idx_q;
				w_pid   = pidc_q;
				w_st    = rrps_pkg::SLOT_READY;
				w_link  = cur_link_q;
				w_ks    = is_user_op ? top : 32'd0;
				w_user  = is_user_op;
				esp_we  = 1'b1;
				esp_wa  = idx_q;
				esp_wd  = top - (is_user_op ? rrps_pkg::USER_FRAME : rrps_pkg::KERN_FRAME);
				root_we = 1'b1;
				root_wd = is_user_op ? req_q.new_root : kroot_q;
			end
			rrps_pkg::CMD_LINK: begin
				rec_we = 1'b1;
				rec_wa = cur_q;
				w_link = idx_q;
			end
			rrps_pkg::CMD_LEAVE: begin
				rec_we = 1'b1;
				rec_wa = cur_q;
				w_pid  = r_pid;
				w_st   = is_tick ? rrps_pkg::SLOT_READY : rrps_pkg::SLOT_DEAD;
				w_link = r_link;
				w_ks   = r_ks;
				w_user = r_user;
				esp_we = 1'b1;
				esp_wa = cur_q;
				esp_wd = req_q.saved_esp;
				rec_re = 1'b1;
				rec_ra = r_link;
			end
			rrps_pkg::CMD_FOLLOW: begin
				rec_re = 1'b1;
				rec_ra = v_link;
			end
			rrps_pkg::CMD_SELECT: begin
				rec_we  = 1'b1;
				rec_wa  = nx;
				w_pid   = sel_pid;
				w_st    = rrps_pkg::SLOT_RUNNING;
				w_link  = walk_hit ? v_link : cur_link_q;
				w_ks    = sel_ks;
				w_user  = sel_user;
				side_re = 1'b1;
			end
			default: ;
		endcase
	end

	// result staging
	always_comb begin
		res_d  = '0;
		res_we = 1'b1;
		case (cmd.code)
			rrps_pkg::CMD_HALT_RES, rrps_pkg::CMD_STOP_RES: begin
				res_d.status = rrps_pkg::RES_HALTED;
			end
			rrps_pkg::CMD_QUERY_RES: begin
				res_d.running_pid = r_pid;
			end
			rrps_pkg::CMD_FULL_RES: begin
				res_d.status      = rrps_pkg::RES_FULL;
				res_d.running_pid = r_pid;
			end
			rrps_pkg::CMD_NOFREE_RES: begin
				res_d.status      = rrps_pkg::RES_NO_SLOT;
				res_d.running_pid = cur_pid_q;
			end
			rrps_pkg::CMD_CREATE: begin
				res_d.new_pid     = pidc_q;
				res_d.running_pid = cur_pid_q;
			end
			rrps_pkg::CMD_REPORT: begin
				res_d.running_pid    = sel_pid_q;
				res_d.resume_esp     = esp_rd_q;
				res_d.resume_root    = sel_user_q ? root_rd_q : kroot_q;
				res_d.kstack_top_out = sel_ks_q;
				res_d.load_kstack    = (sel_ks_q != 32'd0);
				res_d.switched       = switched_q;
			end
			default: res_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kroot_q <= '0;
			cur_q   <= '0;
			pidc_q  <= 32'd2;
			live_q  <= CW'(1);
			halt_q  <= 1'b0;
			idx_q   <= '0;
			cnt_q   <= '0;
			vld_q   <= '0;
		end else begin
			if (cfg_we) begin
				kroot_q <= cfg_wdata;
			end
			if (rec_we) begin
				vld_q[rec_wa] <= 1'b1;
			end
			case (cmd.code)
				rrps_pkg::CMD_SCAN_START: idx_q <= '0;
				rrps_pkg::CMD_SCAN: idx_q <= idx_q + 1'b1;
				rrps_pkg::CMD_CREATE: begin
					pidc_q <= pidc_q + 32'd1;
					live_q <= live_q + 1'b1;
				end
				rrps_pkg::CMD_LEAVE: begin
					idx_q <= r_link;
					cnt_q <= '0;
					if (is_exit && (live_q != '0)) begin
						live_q <= live_q - 1'b1;
					end
				end
				rrps_pkg::CMD_FOLLOW: begin
					idx_q <= v_link;
					cnt_q <= cnt_q + 1'b1;
				end
				rrps_pkg::CMD_SELECT: cur_q <= nx;
				rrps_pkg::CMD_STOP_RES: halt_q <= 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.code)
			rrps_pkg::CMD_LOAD: req_q <= req_data;
			rrps_pkg::CMD_SCAN_START, rrps_pkg::CMD_LEAVE: begin
				cur_pid_q  <= r_pid;
				cur_st_q   <= is_tick ? rrps_pkg::SLOT_READY : r_st;
				cur_link_q <= r_link;
				cur_ks_q   <= r_ks;
				cur_user_q <= r_user;
			end
			rrps_pkg::CMD_SELECT: begin
				sel_pid_q  <= sel_pid;
				sel_ks_q   <= sel_ks;
				sel_user_q <= sel_user;
				switched_q <= (nx != cur_q);
			end
			rrps_pkg::CMD_PUSH: out_q <= res_q;
			default: ;
		endcase
		if (res_we) begin
			res_q <= res_d;
		end
	end

	// slot record memory
	always_ff @(posedge clk) begin
		if (rec_we) begin
			pid_mem[rec_wa]  <= w_pid;
			st_mem[rec_wa]   <= w_st;
			link_mem[rec_wa] <= w_link;
			ks_mem[rec_wa]   <= w_ks;
			user_mem[rec_wa] <= w_user;
		end
		if (rec_re) begin
			rd_pid_q  <= pid_mem[rec_ra];
			rd_st_q   <= st_mem[rec_ra];
			rd_link_q <= link_mem[rec_ra];
			rd_ks_q   <= ks_mem[rec_ra];
			rd_user_q <= user_mem[rec_ra];
			rd_vld_q  <= vld_q[rec_ra];
			rd_addr_q <= rec_ra;
		end
	end

	// saved stack pointer memory
	always_ff @(posedge clk) begin
		if (esp_we) begin
			esp_mem[esp_wa] <= esp_wd;
		end
		if (side_re) begin
			esp_rd_q <= esp_mem[nx];
		end
	end

	// address-space root memory
	always_ff @(posedge clk) begin
		if (root_we) begin
			root_mem[idx_q] <= root_wd;
		end
		if (side_re) begin
			root_rd_q <= root_mem[nx];
		end
	end

endmodule

>>> design/rrps_ctrl.sv
// ----------------------------------------------------------------------------
// rrps_ctrl: scheduler controller
// Sequences one request through decode, free-slot scan or ring walk,
// result staging and the output register handshake.
// ----------------------------------------------------------------------------
module rrps_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	input  rrps_pkg::dp_sts_t sts,
	output rrps_pkg::dp_cmd_t cmd
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_DEC    = 3'd1;
	localparam logic [2:0] S_SCAN   = 3'd2;
	localparam logic [2:0] S_LINK   = 3'd3;
	localparam logic [2:0] S_WALK   = 3'd4;
	localparam logic [2:0] S_REPORT = 3'd5;
	localparam logic [2:0] S_PUSH   = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;
	logic       push_ok;

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = out_valid_q;
	assign push_ok   = !out_valid_q || rsp_ready;

	always_comb begin
		state_d  = state_q;
		cmd.code = rrps_pkg::CMD_NONE;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.code = rrps_pkg::CMD_LOAD;
					state_d  = S_DEC;
				end
			end
			S_DEC: begin
				if (sts.halted) begin
					cmd.code = rrps_pkg::CMD_HALT_RES;
					state_d  = S_PUSH;
				end else if (sts.is_create) begin
					if (sts.full) begin
						cmd.code = rrps_pkg::CMD_FULL_RES;
						state_d  = S_PUSH;
					end else begin
						cmd.code = rrps_pkg::CMD_SCAN_START;
						state_d  = S_SCAN;
					end
				end else if (sts.is_tick || sts.is_exit) begin
					cmd.code = rrps_pkg::CMD_LEAVE;
					state_d  = S_WALK;
				end else begin
					cmd.code = rrps_pkg::CMD_QUERY_RES;
					state_d  = S_PUSH;
				end
			end
			S_SCAN: begin
				if (sts.slot_free) begin
					cmd.code = rrps_pkg::CMD_CREATE;
					state_d  = S_LINK;
				end else if (sts.scan_last) begin
					cmd.code = rrps_pkg::CMD_NOFREE_RES;
					state_d  = S_PUSH;
				end else begin
					cmd.code = rrps_pkg::CMD_SCAN;
				end
			end
			S_LINK: begin
				cmd.code = rrps_pkg::CMD_LINK;
				state_d  = S_PUSH;
			end
			S_WALK: begin
				// a tick that finds nothing else keeps the current slot
				if (sts.walk_hit || (sts.walk_end && sts.is_tick)) begin
					cmd.code = rrps_pkg::CMD_SELECT;
					state_d  = S_REPORT;
				end else if (sts.walk_end) begin
					cmd.code = rrps_pkg::CMD_STOP_RES;
					state_d  = S_PUSH;
				end else begin
					cmd.code = rrps_pkg::CMD_FOLLOW;
				end
			end
			S_REPORT: begin
				cmd.code = rrps_pkg::CMD_REPORT;
				state_d  = S_PUSH;
			end
			S_PUSH: begin
				if (push_ok) begin
					cmd.code = rrps_pkg::CMD_PUSH;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.code == rrps_pkg::CMD_PUSH) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

>>> bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for round_robin_process_scheduler
// Drives create, tick, exit, query and spare requests through the valid/ready
// channels, predicts every response from a private copy of the slot table and
// compares each response field by field, under three idling patterns and
// several page directory settings for kernel processes.
// ----------------------------------------------------------------------------
module testbench;
	import rrps_pkg::*;

	localparam int SLOTS = MAX_SLOTS_DEF;
	localparam int SETTLE_CYCLES = SLOTS + 8;
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int PHASE_ITEMS = 640;
	localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
	localparam logic [2:0] OP_SPARE_LAST = 3'd7;
	localparam logic [31:0] ALL_ONES = 32'hffff_ffff;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [31:0] cfg_wdata;

	rrps_chan_if #(.T(req_t)) req_ch ();
	rrps_chan_if #(.T(rsp_t)) rsp_ch ();

	round_robin_process_scheduler #(.MAX_SLOTS(SLOTS)) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	// private copy of the slot table
	logic [31:0] sched_pid [SLOTS];
	logic [1:0]  sched_state [SLOTS];
	int          sched_link [SLOTS];
	logic [31:0] sched_esp [SLOTS];
	logic [31:0] sched_root [SLOTS];
	logic [31:0] sched_kstack [SLOTS];
	logic        sched_user [SLOTS];
	int          sched_cur;
	int          sched_live;
	logic [31:0] sched_next_pid;
	logic [31:0] sched_kernel_root;
	bit          sched_halted;
	bit          table_filled;

	rsp_t pending_responses [$];
	int   mismatch_count = 0;
	int   tx_idle_pct = 29;
	int   rx_idle_pct = 87;
	int   cycle_count = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin : receiver
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			rsp_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
		end
	end

	task automatic report_mismatch(string msg);
		$display("mismatch at %0t: %s", $time, msg);
		mismatch_count++;
	endtask

	task automatic compare_field(string name, logic [31:0] got, logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %h, expected %h", name, got, want));
	endtask

	always @(posedge clk) begin : response_check
		rsp_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_responses.size() == 0) begin
				report_mismatch($sformatf("response with none pending, status %0d",
					rsp_ch.data.status));
			end else begin
				want = pending_responses.pop_front();
				compare_field("status", 32'(rsp_ch.data.status), 32'(want.status));
				compare_field("new_pid", rsp_ch.data.new_pid, want.new_pid);
				compare_field("running_pid", rsp_ch.data.running_pid, want.running_pid);
				compare_field("resume_esp", rsp_ch.data.resume_esp, want.resume_esp);
				compare_field("resume_root", rsp_ch.data.resume_root, want.resume_root);
				compare_field("kstack_top_out", rsp_ch.data.kstack_top_out,
					want.kstack_top_out);
				compare_field("load_kstack", 32'(rsp_ch.data.load_kstack),
					32'(want.load_kstack));
				compare_field("switched", 32'(rsp_ch.data.switched), 32'(want.switched));
			end
		end
	end

	task automatic reset_schedule();
		for (int i = 0; i < SLOTS; i++) begin
			sched_pid[i] = '0;
			sched_state[i] = SLOT_DEAD;
			sched_link[i] = 0;
			sched_esp[i] = '0;
			sched_root[i] = '0;
			sched_kstack[i] = '0;
			sched_user[i] = 1'b0;
		end
		sched_pid[0] = 32'd1;
		sched_state[0] = SLOT_RUNNING;
		sched_cur = 0;
		sched_live = 1;
		sched_next_pid = 32'd2;
		sched_kernel_root = '0;
		sched_halted = 1'b0;
		table_filled = 1'b0;
	endtask

	function automatic rsp_t running_view(int prev);
		rsp_t r = '0;
		r.status = RES_OK;
		r.running_pid = sched_pid[sched_cur];
		r.resume_esp = sched_esp[sched_cur];
		r.resume_root = sched_user[sched_cur] ? sched_root[sched_cur] : sched_kernel_root;
		r.kstack_top_out = sched_kstack[sched_cur];
		r.load_kstack = (sched_kstack[sched_cur] != '0);
		r.switched = (sched_cur != prev);
		return r;
	endfunction

	// applies one request to the slot table and returns the response it earns
	function automatic rsp_t schedule_request(req_t rq);
		rsp_t r = '0;
		int   cur = sched_cur;
		int   nx = sched_link[sched_cur];
		int   free_slot = -1;
		bit   found = 1'b0;
		bit   user = (rq.op == OP_CREATE_USER);
		if (sched_halted) begin
			r.status = RES_HALTED;
			return r;
		end
		case (rq.op)
			OP_CREATE_KERN, OP_CREATE_USER: begin
				if (sched_live >= SLOTS) begin
					r.status = RES_FULL;
					table_filled = 1'b1;
				end else begin
					// exited slots keep their pid, so only never-used slots are free
					for (int i = SLOTS - 1; i >= 0; i--)
						if (sched_state[i] == SLOT_DEAD && sched_pid[i] == '0)
							free_slot = i;
					if (free_slot < 0) begin
						r.status = RES_NO_SLOT;
					end else begin
						sched_pid[free_slot] = sched_next_pid;
						sched_next_pid = sched_next_pid + 32'd1;
						sched_user[free_slot] = user;
						sched_kstack[free_slot] = user ? rq.new_stack_top : '0;
						sched_root[free_slot] = user ? rq.new_root : sched_kernel_root;
						sched_esp[free_slot] = rq.new_stack_top - (user ? USER_FRAME : KERN_FRAME);
						sched_state[free_slot] = SLOT_READY;
						sched_link[free_slot] = sched_link[cur];
						sched_link[cur] = free_slot;
						sched_live++;
						r.new_pid = sched_pid[free_slot];
					end
				end
				r.running_pid = sched_pid[sched_cur];
			end
			OP_TICK: begin
				sched_esp[cur] = rq.saved_esp;
				sched_state[cur] = SLOT_READY;
				// the current slot is ready itself, so the walk always ends on one
				for (int n = 0; n < SLOTS && sched_state[nx] != SLOT_READY; n++)
					nx = sched_link[nx];
				sched_cur = nx;
				sched_state[nx] = SLOT_RUNNING;
				r = running_view(cur);
			end
			OP_EXIT: begin
				sched_esp[cur] = rq.saved_esp;
				sched_state[cur] = SLOT_DEAD;
				if (sched_live > 0)
					sched_live--;
				for (int n = 0; n < SLOTS && !found; n++) begin
					if (sched_state[nx] == SLOT_READY)
						found = 1'b1;
					else
						nx = sched_link[nx];
				end
				if (!found) begin
					sched_halted = 1'b1;
					r.status = RES_HALTED;
				end else begin
					sched_cur = nx;
					sched_state[nx] = SLOT_RUNNING;
					r = running_view(cur);
				end
			end
			default: r.running_pid = sched_pid[sched_cur];
		endcase
		return r;
	endfunction

	function automatic logic [31:0] random_word();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return ALL_ONES;
			default: return $urandom;
		endcase
	endfunction

	task automatic send_request(logic [2:0] op, logic [31:0] esp, logic [31:0] top,
		logic [31:0] root);
		int   gap = 0;
		req_t rq;
		rq.op = op;
		rq.saved_esp = esp;
		rq.new_stack_top = top;
		rq.new_root = root;
		while ($urandom_range(0, 99) < tx_idle_pct)
			gap++;
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.data <= rq;
		do @(posedge clk); while (!req_ch.ready);
		pending_responses.push_back(schedule_request(rq));
	endtask

	task automatic wait_idle();
		req_ch.valid <= 1'b0;
		while (pending_responses.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_kernel_root(logic [31:0] value);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		sched_kernel_root = value;
	endtask

	task automatic send_random_request();
		int         pick = $urandom_range(0, 99);
		logic [2:0] op;
		if (pick < 22)
			op = $urandom_range(0, 1) ? OP_CREATE_USER : OP_CREATE_KERN;
		else if (pick < 70)
			op = OP_TICK;
		else if (pick < 80)
			op = OP_QUERY;
		else if (pick < 85)
			op = 3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
		// exits only once the table has filled, and never down to a halt here
		else if (pick < 87 && table_filled && sched_live > 2)
			op = OP_EXIT;
		else
			op = OP_TICK;
		send_request(op, random_word(), random_word(), random_word());
	endtask

	task automatic test_lone_process();
		send_request(OP_QUERY, random_word(), random_word(), random_word());
		send_request(OP_TICK, '0, random_word(), random_word());
		send_request(OP_TICK, ALL_ONES, random_word(), random_word());
		for (int op = OP_SPARE_FIRST; op <= OP_SPARE_LAST; op++)
			send_request(3'(op), random_word(), random_word(), random_word());
	endtask

	task automatic test_create_kinds();
		send_request(OP_CREATE_KERN, random_word(), '0, random_word());
		send_request(OP_CREATE_USER, random_word(), ALL_ONES, ALL_ONES);
		// user process with a zero stack top: no stack load
		send_request(OP_CREATE_USER, random_word(), '0, '0);
		send_request(OP_CREATE_KERN, random_word(), ALL_ONES, random_word());
	endtask

	task automatic test_ring_walk();
		for (int i = 0; i < 5; i++)
			send_request(OP_TICK, i[0] ? ALL_ONES : '0, random_word(), random_word());
		send_request(OP_QUERY, random_word(), random_word(), random_word());
	endtask

	task automatic test_random_phase(int tx_pct, int rx_pct, logic [31:0] kroot);
		write_kernel_root(kroot);
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		for (int i = 0; i < PHASE_ITEMS; i++)
			send_random_request();
	endtask

	task automatic test_drain_and_halt();
		write_kernel_root($urandom);
		while (!sched_halted) begin
			if (sched_live == 1)
				send_request(OP_TICK, random_word(), random_word(), random_word());
			send_request(OP_EXIT, random_word(), random_word(), random_word());
		end
		for (int op = OP_CREATE_KERN; op <= OP_SPARE_LAST; op++)
			send_request(3'(op), random_word(), random_word(), random_word());
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		req_ch.valid <= 1'b0;
		req_ch.data <= '0;
		reset_schedule();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_lone_process();
		write_kernel_root(ALL_ONES);
		test_create_kinds();
		test_ring_walk();
		test_random_phase(29, 87, $urandom);
		test_random_phase(87, 29, '0);
		test_random_phase(0, 0, ALL_ONES);
		test_drain_and_halt();

		wait_idle();
		if (mismatch_count == 0 && pending_responses.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
